// ===== hdl/bsc_pkg.sv =====
// Package for the base64 stream codec: job type passed from front to back,
// character constants, alphabet and digit functions. No dependencies.
package bsc_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DECODE_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 1'd1;

    // Job queue geometry (depth is a power of two so the pointers wrap).
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Characters of the alphabet and the pad character.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;

    // Digit ranges of the alphabet.
    localparam logic [5:0] DIGIT_LOWER_BASE = 6'd26;
    localparam logic [5:0] DIGIT_NUM_BASE   = 6'd52;
    localparam logic [5:0] DIGIT_PLUS       = 6'd62;
    localparam logic [5:0] DIGIT_SLASH      = 6'd63;

    // One job: up to four result words, released in order from bytes[0].
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_pos;  // index of the final word of the job
        logic            empty;     // single word carrying no byte
        logic            last;      // final word of the job ends the message
    } t_job;

    // Result of classifying one text character.
    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_digit;

    // Map a six-bit digit to its alphabet character.
    function automatic logic [7:0] alpha_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < DIGIT_LOWER_BASE) begin
            c = CHAR_UPPER_A + {2'b00, v};
        end else if (v < DIGIT_NUM_BASE) begin
            c = CHAR_LOWER_A + {2'b00, v - DIGIT_LOWER_BASE};
        end else if (v < DIGIT_PLUS) begin
            c = CHAR_ZERO + {2'b00, v - DIGIT_NUM_BASE};
        end else if (v == DIGIT_PLUS) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

    // Classify a character; anything outside the alphabet is not a digit.
    function automatic t_digit digit_decode(input logic [7:0] c);
        t_digit d;
        d.valid = 1'b1;
        d.value = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d.value = 6'(c - CHAR_UPPER_A);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d.value = 6'(c - CHAR_LOWER_A) + DIGIT_LOWER_BASE;
        end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d.value = 6'(c - CHAR_ZERO) + DIGIT_NUM_BASE;
        end else if (c == CHAR_PLUS) begin
            d.value = DIGIT_PLUS;
        end else if (c == CHAR_SLASH) begin
            d.value = DIGIT_SLASH;
        end else begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== hdl/bsc_in_if.sv =====
// Input channel of the base64 stream codec: valid/ready handshake with one
// message byte and its end flag. No dependencies.
interface bsc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hdl/bsc_out_if.sv =====
// Output channel of the base64 stream codec: valid/ready handshake with one
// result word. No dependencies.
interface bsc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_has_byte, input out_last,
                    output ready);
endinterface

// ===== hdl/bsc_front.sv =====
// Front end of the base64 stream codec: configuration registers, group state,
// and conversion of each accepted word into a job. Depends on bsc_pkg, bsc_in_if.
module bsc_front
    import bsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    bsc_in_if.sink                i_in_ch,
    input  logic                  i_q_full,
    output logic                  o_q_push,
    output t_job                  o_q_job
);

    logic        r_decode_mode;
    logic        r_enable;
    logic [17:0] r_group_bits;
    logic [1:0]  r_group_count;
    logic [17:0] n_group_bits;
    logic [1:0]  n_group_count;
    logic        accept;

    // The front takes a word whenever the job queue has room.
    assign i_in_ch.ready = !i_q_full;
    assign accept        = i_in_ch.valid && !i_q_full;

    // Group update and job build for the accepted word.
    always_comb begin
        logic [23:0] enc_bits;
        logic [2:0]  enc_cnt;
        logic [23:0] pad_bits;
        t_digit      dig;
        logic [23:0] dec_full;
        logic [17:0] dec_gb;
        logic [1:0]  dec_gc;

        n_group_bits  = r_group_bits;
        n_group_count = r_group_count;
        o_q_push      = 1'b0;
        o_q_job       = '0;

        enc_bits = {r_group_bits[15:0], i_in_ch.in_byte};
        enc_cnt  = {1'b0, r_group_count} + 3'd1;
        pad_bits = (enc_cnt == 3'd1) ? {i_in_ch.in_byte, 16'h0000}
                                     : {r_group_bits[7:0], i_in_ch.in_byte, 8'h00};
        dig      = digit_decode(i_in_ch.in_byte);
        dec_full = {r_group_bits, dig.value};
        dec_gb   = r_group_bits;
        dec_gc   = r_group_count;

        if (accept) begin
            priority if (!r_enable) begin
                // Disabled: drop the word, restart the group at message end.
                if (i_in_ch.in_last) begin
                    n_group_bits  = '0;
                    n_group_count = '0;
                end
            end else if (!r_decode_mode) begin
                if (enc_cnt >= 3'd3) begin
                    // Full group of three bytes gives four characters.
                    o_q_push           = 1'b1;
                    o_q_job.bytes[0]   = alpha_char(enc_bits[23:18]);
                    o_q_job.bytes[1]   = alpha_char(enc_bits[17:12]);
                    o_q_job.bytes[2]   = alpha_char(enc_bits[11:6]);
                    o_q_job.bytes[3]   = alpha_char(enc_bits[5:0]);
                    o_q_job.last_pos   = 2'd3;
                    o_q_job.last       = i_in_ch.in_last;
                    n_group_bits       = '0;
                    n_group_count      = '0;
                end else if (i_in_ch.in_last) begin
                    // Short final group is padded out to four characters.
                    o_q_push           = 1'b1;
                    o_q_job.bytes[0]   = alpha_char(pad_bits[23:18]);
                    o_q_job.bytes[1]   = alpha_char(pad_bits[17:12]);
                    o_q_job.bytes[2]   = (enc_cnt == 3'd2) ? alpha_char(pad_bits[11:6])
                                                           : CHAR_PAD;
                    o_q_job.bytes[3]   = CHAR_PAD;
                    o_q_job.last_pos   = 2'd3;
                    o_q_job.last       = 1'b1;
                    n_group_bits       = '0;
                    n_group_count      = '0;
                end else begin
                    n_group_bits  = {2'b00, enc_bits[15:0]};
                    n_group_count = enc_cnt[1:0];
                end
            end else begin
                // Decode: gather digits, skip anything outside the alphabet.
                if (dig.valid) begin
                    if (r_group_count == 2'd3) begin
                        o_q_push         = 1'b1;
                        o_q_job.bytes[0] = dec_full[23:16];
                        o_q_job.bytes[1] = dec_full[15:8];
                        o_q_job.bytes[2] = dec_full[7:0];
                        o_q_job.last_pos = 2'd2;
                        o_q_job.last     = i_in_ch.in_last;
                        dec_gb           = '0;
                        dec_gc           = '0;
                    end else begin
                        dec_gb = dec_full[17:0];
                        dec_gc = r_group_count + 2'd1;
                    end
                end
                n_group_bits  = dec_gb;
                n_group_count = dec_gc;
                if (i_in_ch.in_last) begin
                    n_group_bits  = '0;
                    n_group_count = '0;
                    // A full group already carries the end flag; otherwise
                    // flush the partial group or send the empty end marker.
                    if (!o_q_push) begin
                        o_q_push     = 1'b1;
                        o_q_job.last = 1'b1;
                        unique case (dec_gc)
                            2'd2: begin
                                o_q_job.bytes[0] = dec_gb[11:4];
                                o_q_job.last_pos = 2'd0;
                            end
                            2'd3: begin
                                o_q_job.bytes[0] = dec_gb[17:10];
                                o_q_job.bytes[1] = dec_gb[9:2];
                                o_q_job.last_pos = 2'd1;
                            end
                            default: begin
                                o_q_job.empty    = 1'b1;
                                o_q_job.last_pos = 2'd0;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // Configuration and group state; a mode write restarts the group.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_enable      <= 1'b1;
            r_group_bits  <= '0;
            r_group_count <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_DECODE_MODE) begin
                r_decode_mode <= i_cfg_wdata[0];
                r_group_bits  <= '0;
                r_group_count <= '0;
            end else if (i_cfg_index == CFG_ENABLE) begin
                r_enable <= i_cfg_wdata[0];
            end
        end else begin
            r_group_bits  <= n_group_bits;
            r_group_count <= n_group_count;
        end
    end

    // An encode group never holds three bytes between words.
    a_enc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_decode_mode |-> r_group_count != 2'd3)
        else $error("encode group count reached three");

    // Jobs are only created for accepted words.
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> (i_in_ch.valid && !i_q_full))
        else $error("job pushed without an accepted word");

    // The empty end marker always closes a message.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && o_q_job.empty) |-> o_q_job.last)
        else $error("empty job without end flag");

endmodule

// ===== hdl/bsc_queue.sv =====
// Short job queue between the front and back of the base64 stream codec.
// Depends on bsc_pkg.
module bsc_queue
    import bsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count; pointers wrap since the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full job queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty job queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("job queue count beyond depth");

endmodule

// ===== hdl/bsc_back.sv =====
// Back end of the base64 stream codec: serializes the head job into result
// words through an output register. Depends on bsc_pkg, bsc_out_if.
module bsc_back
    import bsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_job     i_q_job,
    output logic     o_q_pop,
    bsc_out_if.source o_out_ch
);

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_has_byte;
    logic       r_out_last;
    logic [1:0] r_pos;
    logic       advance;

    // The output register takes a new word when empty or being drained.
    assign advance = !r_out_valid || o_out_ch.ready;
    assign o_q_pop = advance && i_q_valid && (r_pos == i_q_job.last_pos);

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.out_byte     = r_out_byte;
    assign o_out_ch.out_has_byte = r_out_has_byte;
    assign o_out_ch.out_last     = r_out_last;

    // Output valid and position within the head job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else if (advance) begin
            r_out_valid <= i_q_valid;
            if (i_q_valid) begin
                r_pos <= o_q_pop ? 2'd0 : r_pos + 2'd1;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (advance && i_q_valid) begin
            r_out_byte     <= i_q_job.bytes[r_pos];
            r_out_has_byte <= !i_q_job.empty;
            r_out_last     <= i_q_job.last && (r_pos == i_q_job.last_pos);
        end
    end

    a_pos_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> r_pos <= i_q_job.last_pos)
        else $error("word position beyond head job");

    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> r_pos == 2'd0)
        else $error("word position not cleared with queue empty");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_q_job.last) |=> (r_out_valid && r_out_last))
        else $error("message end not shown on final word");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has_byte) |-> r_out_last)
        else $error("empty marker without end flag");

endmodule

// ===== hdl/base64_stream_codec.sv =====
// Base64 stream codec top level: front end, job queue and back end.
// Depends on bsc_pkg, bsc_in_if, bsc_out_if, bsc_front, bsc_queue, bsc_back.
//
// Usage: message bytes enter on i_in_ch (valid/ready), the final byte of a
// message flagged by in_last. Results leave on o_out_ch, one word per
// handshake: out_byte, out_has_byte (low only for the empty end marker) and
// out_last on the final word of a message. Configuration writes use i_cfg_we,
// i_cfg_index and i_cfg_wdata: index 0 selects decode mode and restarts the
// group, index 1 enables the transform. Write only while the block is idle.
// The first word of a job goes into the job queue at the edge that accepts
// the input word completing it, then to the output register; the rest follow
// one per cycle. The output side runs one word per cycle while the receiver
// keeps up, so encoding is bound by the four characters per three input bytes
// and decoding sustains one text character per cycle. The input takes a word
// in the same cycle that an earlier result waits; it stalls only when the
// two-entry job queue is full. A stalled receiver holds the output word, then
// fills the queue, then backs up to the input. Synchronous reset empties the
// queue and output register, clears the group, selects encode mode, enabled.
module base64_stream_codec
    import bsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    bsc_in_if.sink                i_in_ch,
    bsc_out_if.source             o_out_ch
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_job q_in_job;
    t_job q_out_job;

    bsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_ch     (i_in_ch),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_job     (q_in_job)
    );

    bsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    bsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_out_job),
        .o_q_pop   (q_pop),
        .o_out_ch  (o_out_ch)
    );

endmodule
